// File: hw/rtl/ecgdf_pkg.sv
// Shared types and constants for the ECG frame deframer.
package ecgdf_pkg;

  // Default frame geometry.
  localparam int unsigned PayloadBytesDef = 512;
  localparam int unsigned ChannelsDef     = 8;

  // Framing bytes on the link.
  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] DataHdr  = 8'hDA;
  localparam logic [7:0] CmdHdr   = 8'hC0;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  // Parser state, one-hot.
  typedef enum logic [7:0] {
    ST_SYNC1  = 8'b0000_0001,
    ST_SYNC2  = 8'b0000_0010,
    ST_HEADER = 8'b0000_0100,
    ST_CMD    = 8'b0000_1000,
    ST_DATA   = 8'b0001_0000,
    ST_TRL0   = 8'b0010_0000,
    ST_TRL1   = 8'b0100_0000,
    ST_TRL2   = 8'b1000_0000
  } parse_state_e;

  // One result as produced by the parser for the current byte.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [2:0]  channel;
    logic [7:0]  sample_index;
    logic [15:0] sample_value;
  } result_t;

endpackage

// File: hw/rtl/ecgdf_byte_if.sv
// Valid/ready channel carrying one received link byte per beat.
interface ecgdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/ecgdf_result_if.sv
// Valid/ready channel carrying one deframer result per beat.
interface ecgdf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  channel;
  logic [7:0]  sample_index;
  logic [15:0] sample_value;

  modport source (output valid, output kind, output channel, output sample_index,
                  output sample_value, input ready);
  modport sink   (input valid, input kind, input channel, input sample_index,
                  input sample_value, output ready);
endinterface

// File: hw/rtl/ecgdf_parser.sv
// Frame parser state machine: sync hunt, header decode, sample assembly, trailer check.
module ecgdf_parser #(
  parameter int unsigned PAYLOAD_BYTES = ecgdf_pkg::PayloadBytesDef,
  parameter int unsigned CHANNELS      = ecgdf_pkg::ChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  output ecgdf_pkg::result_t  result_o
);

  localparam int unsigned BcW = $clog2(PAYLOAD_BYTES);
  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [BcW-1:0] LastByte = BcW'(PAYLOAD_BYTES - 1);
  localparam logic [ChW-1:0] LastChan = ChW'(CHANNELS - 1);

  ecgdf_pkg::parse_state_e state_q, state_d;
  logic [BcW-1:0] count_q, count_d;
  logic [ChW-1:0] chan_q, chan_d;
  logic [7:0]     high_q, high_d;
  logic           bad_q, bad_d;

  logic             is_sync;
  logic             trl_bad;
  logic [BcW+6:0]   idx_ext;
  logic [ChW+2:0]   chan_ext;

  assign is_sync  = (rx_byte_i == ecgdf_pkg::SyncByte);
  assign trl_bad  = bad_q | (rx_byte_i != ecgdf_pkg::DataHdr);
  assign idx_ext  = {8'b0, count_q[BcW-1:1]};
  assign chan_ext = {3'b0, chan_q};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    chan_d   = chan_q;
    high_d   = high_q;
    bad_d    = bad_q;
    result_o = '0;
    result_o.kind = ecgdf_pkg::KIND_SAMPLE;
    unique case (state_q)
      ecgdf_pkg::ST_SYNC1: begin
        if (is_sync) state_d = ecgdf_pkg::ST_SYNC2;
      end
      ecgdf_pkg::ST_SYNC2: begin
        state_d = is_sync ? ecgdf_pkg::ST_HEADER : ecgdf_pkg::ST_SYNC1;
      end
      ecgdf_pkg::ST_HEADER: begin
        if (rx_byte_i == ecgdf_pkg::DataHdr) begin
          state_d = ecgdf_pkg::ST_DATA;
          count_d = '0;
          chan_d  = '0;
        end else if (rx_byte_i == ecgdf_pkg::CmdHdr) begin
          state_d = ecgdf_pkg::ST_CMD;
        end else begin
          state_d = ecgdf_pkg::ST_SYNC1;
        end
      end
      ecgdf_pkg::ST_CMD: begin
        state_d = ecgdf_pkg::ST_SYNC1;
      end
      ecgdf_pkg::ST_DATA: begin
        if (!count_q[0]) begin
          high_d = rx_byte_i;
        end else begin
          result_o.valid        = 1'b1;
          result_o.kind         = ecgdf_pkg::KIND_SAMPLE;
          result_o.channel      = chan_ext[2:0];
          result_o.sample_index = idx_ext[7:0];
          result_o.sample_value = {high_q, rx_byte_i};
          chan_d = (chan_q == LastChan) ? '0 : chan_q + 1'b1;
        end
        if (count_q == LastByte) begin
          state_d = ecgdf_pkg::ST_TRL0;
          bad_d   = 1'b0;
          count_d = '0;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      ecgdf_pkg::ST_TRL0: begin
        bad_d   = !is_sync;
        state_d = ecgdf_pkg::ST_TRL1;
      end
      ecgdf_pkg::ST_TRL1: begin
        bad_d   = bad_q | !is_sync;
        state_d = ecgdf_pkg::ST_TRL2;
      end
      ecgdf_pkg::ST_TRL2: begin
        // A good trailer is also the header of the next data frame.
        result_o.valid = 1'b1;
        result_o.kind  = trl_bad ? ecgdf_pkg::KIND_DISCARD : ecgdf_pkg::KIND_COMMIT;
        state_d = trl_bad ? ecgdf_pkg::ST_SYNC1 : ecgdf_pkg::ST_DATA;
        count_d = '0;
        chan_d  = '0;
        bad_d   = 1'b0;
      end
      default: begin
        state_d = ecgdf_pkg::ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecgdf_pkg::ST_SYNC1;
      count_q <= '0;
      chan_q  <= '0;
      high_q  <= '0;
      bad_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      count_q <= count_d;
      chan_q  <= chan_d;
      high_q  <= high_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// File: hw/rtl/ecg_frame_deframer.sv
// Top level of the ECG frame deframer: input register, parser and result register.
//
// The deframer takes one link byte per beat on rx_i and produces zero or one
// result beat on res_o for each byte. It hunts for the sync pair FF FF, then
// reads a header byte: DA opens a data frame, C0 opens a command frame whose
// single body byte is skipped, and anything else restarts the hunt. A data
// frame carries PAYLOAD_BYTES payload bytes that pair up into big-endian
// 16-bit samples; each sample leaves as a beat of kind 0 as soon as its low
// byte arrives, tagged with its index in the frame and its channel (index
// modulo CHANNELS, both truncated to the field widths). The frame ends in a
// three-byte trailer FF FF DA; its last byte yields a status beat of kind 1
// (commit) when the trailer matched or kind 2 (discard) when it did not. A
// good trailer doubles as the header of the next data frame, while a bad one
// sends the parser back to the sync hunt. Samples of a frame are released
// before its trailer is checked, so a consumer should hold them until the
// status beat arrives. The block sustains one byte per clock cycle while res_o
// keeps taking results: a byte sits in the input register, the parser decodes
// it in one pass of logic, and the result lands in the output register, from
// which res_o offers it. While a finished result waits for res_o.ready, the
// input register can still take one more byte; back-pressure only reaches
// rx_i once both registers are full.
module ecg_frame_deframer #(
  parameter int unsigned PAYLOAD_BYTES = ecgdf_pkg::PayloadBytesDef,
  parameter int unsigned CHANNELS      = ecgdf_pkg::ChannelsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ecgdf_byte_if.sink     rx_i,
  ecgdf_result_if.source res_o
);

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register stage.
  logic               out_valid_q;
  ecgdf_pkg::result_t out_q;

  ecgdf_pkg::result_t parsed;
  logic               advance;

  // The byte in the input register moves on when the result register is
  // free or is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ecgdf_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .CHANNELS     (CHANNELS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .rx_byte_i(in_byte_q),
    .result_o (parsed)
  );

  // A byte that causes no result advances under the same condition as any other,
  // and leaves the result register to drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && parsed.valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && parsed.valid) begin
      out_q <= parsed;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.channel      = out_q.channel;
  assign res_o.sample_index = out_q.sample_index;
  assign res_o.sample_value = out_q.sample_value;

endmodule

// File: tb/ecg_frame_deframer_tb.sv
// Self-checking testbench for the ECG frame deframer with its own deframing predictor.
module ecg_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs with its default frame geometry, and the predictor uses the same numbers.
  localparam int unsigned PAYLOAD     = ecgdf_pkg::PayloadBytesDef;
  localparam int unsigned CHANS       = ecgdf_pkg::ChannelsDef;
  // This watchdog limit sits far above a clean run, even with the longest gaps on both sides.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // This is the length of the long receiver hold-off. It is far longer than the two
  // register stages, so the stall reaches the byte input.
  localparam int unsigned HOLD_CYCLES = 300;

  // This is one result beat as the checker sees it.
  typedef struct {
    ecgdf_pkg::kind_e kind;
    logic [2:0]       channel;
    logic [7:0]       sample_index;
    logic [15:0]      sample_value;
  } beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  ecgdf_byte_if   rx_if ();
  ecgdf_result_if res_if ();

  ecg_frame_deframer #(
    .PAYLOAD_BYTES (PAYLOAD),
    .CHANNELS      (CHANS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // The testbench drives these registers. They carry known values from time zero.
  logic       src_valid = 1'b0;
  logic [7:0] src_byte  = '0;
  logic       snk_ready = 1'b0;

  assign rx_if.valid   = src_valid;
  assign rx_if.rx_byte = src_byte;
  assign res_if.ready  = snk_ready;

  // These hold the bytes still to send and the beats the predictor has worked out.
  logic [7:0]  pending_bytes [$];
  beat_t       expected_beats [$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // The stimulus process sets these to shape the flow on each side.
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  bit hold_req = 1'b0;

  // The predictor keeps its own copy of the parser state. The declared values match reset.
  ecgdf_pkg::parse_state_e link_state  = ecgdf_pkg::ST_SYNC1;
  logic [9:0]              payload_cnt = '0;
  logic [7:0]              held_high   = '0;
  logic                    trailer_bad = 1'b0;

  // Each side uses these to pace itself.
  int unsigned src_gap   = 0;
  bit          src_calm  = 1'b0;
  int unsigned snk_gap   = 0;
  bit          snk_calm  = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;

  function automatic int unsigned draw_gap(input bit idling);
    return idling ? $urandom_range(0, 19) : 0;
  endfunction

  // This task parses one accepted byte and queues the beat that the byte should cause.
  // Samples leave as soon as their low byte arrives. The last trailer byte gives a
  // commit or a discard beat, and a good trailer opens the next frame at once.
  task automatic deframe_byte(input logic [7:0] b);
    beat_t       beat;
    int unsigned idx;
    case (link_state)
      ecgdf_pkg::ST_SYNC1: begin
        if (b == ecgdf_pkg::SyncByte) link_state = ecgdf_pkg::ST_SYNC2;
      end
      ecgdf_pkg::ST_SYNC2: begin
        // A byte that breaks the sync pair is dropped. It never counts as a new first sync.
        link_state = (b == ecgdf_pkg::SyncByte) ? ecgdf_pkg::ST_HEADER : ecgdf_pkg::ST_SYNC1;
      end
      ecgdf_pkg::ST_HEADER: begin
        if (b == ecgdf_pkg::DataHdr) begin
          link_state  = ecgdf_pkg::ST_DATA;
          payload_cnt = '0;
        end else if (b == ecgdf_pkg::CmdHdr) begin
          link_state = ecgdf_pkg::ST_CMD;
        end else begin
          link_state = ecgdf_pkg::ST_SYNC1;
        end
      end
      ecgdf_pkg::ST_CMD: begin
        // The command body is skipped whatever its value.
        link_state = ecgdf_pkg::ST_SYNC1;
      end
      ecgdf_pkg::ST_DATA: begin
        if (!payload_cnt[0]) begin
          held_high = b;
        end else begin
          idx               = payload_cnt >> 1;
          beat.kind         = ecgdf_pkg::KIND_SAMPLE;
          beat.channel      = 3'(idx % CHANS);
          beat.sample_index = 8'(idx);
          beat.sample_value = {held_high, b};
          expected_beats.push_back(beat);
        end
        if (payload_cnt + 1 >= PAYLOAD) begin
          link_state  = ecgdf_pkg::ST_TRL0;
          trailer_bad = 1'b0;
        end
        payload_cnt = payload_cnt + 10'd1;
      end
      ecgdf_pkg::ST_TRL0: begin
        trailer_bad = (b != ecgdf_pkg::SyncByte);
        link_state  = ecgdf_pkg::ST_TRL1;
      end
      ecgdf_pkg::ST_TRL1: begin
        if (b != ecgdf_pkg::SyncByte) trailer_bad = 1'b1;
        link_state = ecgdf_pkg::ST_TRL2;
      end
      ecgdf_pkg::ST_TRL2: begin
        if (b != ecgdf_pkg::DataHdr) trailer_bad = 1'b1;
        beat.kind         = trailer_bad ? ecgdf_pkg::KIND_DISCARD : ecgdf_pkg::KIND_COMMIT;
        beat.channel      = '0;
        beat.sample_index = '0;
        beat.sample_value = '0;
        expected_beats.push_back(beat);
        link_state  = trailer_bad ? ecgdf_pkg::ST_SYNC1 : ecgdf_pkg::ST_DATA;
        payload_cnt = '0;
        trailer_bad = 1'b0;
      end
      default: link_state = ecgdf_pkg::ST_SYNC1;
    endcase
  endtask

  task automatic send(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Payload bytes lean toward the all-zero and all-one values so that both sample
  // extremes turn up often.
  task automatic queue_payload(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       send(8'h00);
        1:       send(8'hFF);
        default: send(8'($urandom));
      endcase
    end
  endtask

  // Each set bit of bad_mask corrupts one trailer byte. The corrupt value always
  // differs from the correct one.
  task automatic queue_trailer(input logic [2:0] bad_mask);
    logic [7:0] want [3];
    want = '{ecgdf_pkg::SyncByte, ecgdf_pkg::SyncByte, ecgdf_pkg::DataHdr};
    for (int i = 0; i < 3; i++) begin
      send(bad_mask[i] ? want[i] ^ 8'($urandom_range(1, 255)) : want[i]);
    end
  endtask

  // Most of the random traffic is data frames, as long as a whole frame still fits in
  // the budget. A good trailer leads straight into the next frame's payload, so a chain
  // runs until one trailer fails or the budget is used up. The rest is command frames
  // and short noise bursts built from framing bytes and random bytes.
  task automatic queue_traffic(input int unsigned budget, input bit lead_with_frame);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned burst;
    bit          chain_on;
    bit          room;
    stop_at = bytes_queued + budget;
    while (bytes_queued < stop_at) begin
      pick = lead_with_frame ? 0 : $urandom_range(0, 99);
      room = (bytes_queued + PAYLOAD + 6 <= stop_at);
      if (pick < 60 && (lead_with_frame || room)) begin
        send(ecgdf_pkg::SyncByte);
        send(ecgdf_pkg::SyncByte);
        send(ecgdf_pkg::DataHdr);
        do begin
          queue_payload(PAYLOAD);
          chain_on = (bytes_queued + PAYLOAD + 6 <= stop_at) &&
                     ($urandom_range(0, 2) == 0);
          queue_trailer(chain_on ? 3'b000 : 3'($urandom_range(1, 7)));
        end while (chain_on);
      end else if (pick < 80) begin
        send(ecgdf_pkg::SyncByte);
        send(ecgdf_pkg::SyncByte);
        send(ecgdf_pkg::CmdHdr);
        send(8'($urandom));
      end else begin
        burst = $urandom_range(1, 6);
        for (int unsigned i = 0; i < burst; i++) begin
          case ($urandom_range(0, 3))
            0:       send(ecgdf_pkg::SyncByte);
            1:       send(ecgdf_pkg::DataHdr);
            2:       send(ecgdf_pkg::CmdHdr);
            default: send(8'($urandom));
          endcase
        end
      end
      lead_with_frame = 1'b0;
    end
  endtask

  // This task returns once every byte is taken and every expected beat has arrived.
  // It looks at the falling edge, when the clocked processes have settled. It then
  // lets the clock run on before it returns, because a byte that causes no beat, such as
  // a command byte, can still be in the pipeline.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || src_valid || expected_beats.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // The byte driver holds a beat until it is taken. It then draws an idle gap for the
  // next byte, or skips the gap during a calm stretch or while idling is off.
  always @(posedge clk_i or negedge rst_ni) begin
    logic       next_valid;
    logic [7:0] next_byte;
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_byte  <= '0;
    end else begin
      next_valid = src_valid;
      next_byte  = src_byte;
      if (src_valid && rx_if.ready) begin
        next_valid = 1'b0;
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
        src_gap = draw_gap(src_idle && !src_calm);
      end
      if (!next_valid) begin
        if (src_gap != 0) begin
          src_gap--;
        end else if (pending_bytes.size() != 0) begin
          next_valid = 1'b1;
          next_byte  = pending_bytes.pop_front();
        end
      end
      src_valid <= next_valid;
      src_byte  <= next_byte;
    end
  end

  // After each result beat the receiver waits a drawn number of cycles before it
  // raises ready again. It holds off once for a long stretch when the stimulus asks.
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_ready;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      next_ready = snk_ready;
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (snk_ready && res_if.valid) begin
        next_ready = 1'b0;
        if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
        snk_gap = draw_gap(snk_idle && !snk_calm);
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!next_ready) begin
        if (snk_gap != 0) snk_gap--;
        else next_ready = 1'b1;
      end
      snk_ready <= next_ready;
    end
  end

  // The monitor predicts from each byte beat taken and checks each result beat taken
  // against the oldest expectation. Both handshakes are sampled at the edge that takes them.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) deframe_byte(rx_if.rx_byte);
      if (res_if.valid && snk_ready) begin
        if (expected_beats.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: result beat with none expected: kind %0d ch %0d idx %0d val %04h",
                     $realtime, res_if.kind, res_if.channel, res_if.sample_index,
                     res_if.sample_value);
          end
          mismatch_cnt++;
        end else begin
          want = expected_beats.pop_front();
          if (res_if.kind !== want.kind || res_if.channel !== want.channel ||
              res_if.sample_index !== want.sample_index ||
              res_if.sample_value !== want.sample_value) begin
            if (mismatch_cnt < 10) begin
              $write("%0t: result mismatch: expected kind %0d ch %0d idx %0d val %04h",
                     $realtime, want.kind, want.channel, want.sample_index,
                     want.sample_value);
              $display(", got kind %0d ch %0d idx %0d val %04h", res_if.kind,
                       res_if.channel, res_if.sample_index, res_if.sample_value);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ecg_frame_deframer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The directed part comes first, with random idling on both sides.
    // A second sync byte that is not FF restarts the hunt.
    send(ecgdf_pkg::SyncByte); send(8'h00);
    // The next two headers are wrong: one is an arbitrary byte and one is a third FF.
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte); send(8'h3C);
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte);
    // This command frame has an FF body. The skipped byte must not count as sync,
    // so the FF DA that follows is a broken pair and does not open a frame.
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::CmdHdr);
    send(ecgdf_pkg::SyncByte);
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::DataHdr);
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::CmdHdr);
    send(ecgdf_pkg::DataHdr);
    // This data frame starts with extreme samples. Its good trailer chains into a
    // second frame, and that frame's trailer ends in a bad last byte.
    send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::SyncByte); send(ecgdf_pkg::DataHdr);
    send(8'hFF); send(8'hFF); send(8'h00); send(8'h00);
    send(8'h80); send(8'h00); send(8'h7F); send(8'hFF);
    send(8'h00); send(8'h01); send(8'hA5); send(8'h5A);
    queue_payload(PAYLOAD - 12);
    queue_trailer(3'b000);
    queue_payload(PAYLOAD);
    queue_trailer(3'b100);
    wait_drained();

    // Random traffic follows, with gaps on both sides.
    queue_traffic(150, 1'b0);
    wait_drained();

    // Under pressure the sender offers bytes back to back while the receiver holds off
    // for a long stretch. The two registers fill, and the byte input stalls.
    src_idle = 1'b0;
    hold_req = 1'b1;
    queue_traffic(60, 1'b1);
    wait_drained();

    // The last stretch runs at full rate on both sides.
    snk_idle = 1'b0;
    queue_traffic(130, 1'b0);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
      $display("ecg_frame_deframer verification clean");
    end else begin
      $display("ecg_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
